FILE: design/dck_pkg.sv
// Shared types and constants of the dominant color chroma key block.
package dck_pkg;

  localparam int unsigned BucketsPerChannelDef = 4;
  localparam int unsigned CountBitsDef = 24;
  localparam logic [7:0] ThresholdReset = 8'd32;
  localparam int unsigned ProdW = 16;
  localparam int unsigned AccW = 18;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_COUNT   = 2'd1,
    OP_COMPOSE = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_KEY,
    ST_MUL,
    ST_DECIDE
  } state_e;

endpackage

FILE: design/dominant_color_chroma_key.sv
// Top level of the chroma keyer that keys on the most common foreground color.
//
// Requests arrive on the s_axis channel: tuser carries the operation (start a
// frame, count a foreground pixel, compose a pixel), tdata the foreground and
// background pixels. Only compose requests produce a result on m_axis: the
// chosen pixel in tdata and a replaced flag in tuser. The threshold register
// is to be written by the user through cfg_we_i and cfg_wdata_i only while
// the block is idle; the block itself does not enforce this.
// The block handles one request at a time; tready is high only when idle.
// A start request clears the histogram, one bin per cycle. A count request
// reads one bin, then increments it and writes it back. A compose request
// goes through the shared multiplier (three squared differences, the squared
// threshold, one compare), after a histogram scan on the first compose after
// a start or count request; a difference below zero counts as zero. After
// reset the histogram is cleared before the first request is taken. The
// result sits in an output register; a stalled receiver holds the next
// compose in its final cycle until the register is free.
module dominant_color_chroma_key #(
  parameter int unsigned BUCKETS_PER_CHANNEL = dck_pkg::BucketsPerChannelDef,
  parameter int unsigned COUNT_BITS = dck_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue
  input  logic [47:0] s_axis_tdata,
  // op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red, out_green, out_blue
  output logic [23:0] m_axis_tdata,
  // replaced
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  import dck_pkg::*;

  localparam int unsigned NumBins = BUCKETS_PER_CHANNEL * BUCKETS_PER_CHANNEL
                                    * BUCKETS_PER_CHANNEL;
  localparam int unsigned BinW = $clog2(NumBins);
  localparam int unsigned BktW = $clog2(BUCKETS_PER_CHANNEL);
  localparam int unsigned BucketSize = 256 / BUCKETS_PER_CHANNEL;
  localparam logic [BinW-1:0] RowStride = BinW'(BUCKETS_PER_CHANNEL * BUCKETS_PER_CHANNEL);
  localparam logic [BinW-1:0] ColStride = BinW'(BUCKETS_PER_CHANNEL);
  localparam logic [BinW-1:0] LastBin = BinW'(NumBins - 1);
  localparam logic [BktW-1:0] LastBkt = BktW'(BUCKETS_PER_CHANNEL - 1);

  function automatic logic [BktW-1:0] bucket_of(input logic [7:0] v);
    logic [BktW-1:0] b;
    b = '0;
    for (int k = 1; k < BUCKETS_PER_CHANNEL; k++) begin
      if (int'(v) >= k * BucketSize) begin
        b = BktW'(k);
      end
    end
    return b;
  endfunction

  function automatic logic [7:0] center_of(input logic [BktW-1:0] b);
    return 8'(int'(b) * BucketSize + BucketSize / 2);
  endfunction

  function automatic logic [BinW-1:0] bin_of(input logic [BktW-1:0] r,
                                             input logic [BktW-1:0] g,
                                             input logic [BktW-1:0] b);
    return BinW'(BinW'(r) * RowStride) + BinW'(BinW'(g) * ColStride) + BinW'(b);
  endfunction

  state_e state_q, state_d;

  logic [2:0][7:0] s_fg, s_bg;
  logic            s_acc;
  op_e             s_op;

  logic [7:0]            thr_q;
  logic                  key_ready_q;
  logic [2:0][7:0]       key_q;
  logic [2:0][7:0]       fg_q, bg_q;
  logic [BinW-1:0]       cnt_addr_q;
  logic [BinW-1:0]       scan_addr_q;
  logic [2:0][BktW-1:0]  scan_bkt_q, scan_bkt_d;
  logic [2:0][BktW-1:0]  cmp_bkt_q;
  logic                  cmp_vld_q;
  logic [COUNT_BITS-1:0] best_cnt_q;
  logic [2:0][BktW-1:0]  best_bkt_q;
  logic [1:0]            step_q;
  logic [ProdW-1:0]      prod_q;
  logic [AccW-1:0]       acc_q;
  logic                  out_vld_q;
  logic [2:0][7:0]       out_pix_q;
  logic                  out_rep_q;

  logic                  mem_we;
  logic [BinW-1:0]       mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [BinW-1:0]       mem_raddr;
  logic [COUNT_BITS-1:0] mem_rdata;

  logic [2:0][7:0] diff;
  logic [7:0]      mul_a, mul_b;
  logic            rep;
  logic            out_free;

  assign s_fg  = s_axis_tdata[23:0];
  assign s_bg  = s_axis_tdata[47:24];
  assign s_op  = op_e'(s_axis_tuser);
  assign s_acc = s_axis_tvalid && s_axis_tready;

  assign out_free = !out_vld_q || m_axis_tready;
  assign rep      = acc_q <= AccW'(prod_q);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = (fg_q[c] > key_q[c]) ? (fg_q[c] - key_q[c]) : 8'd0;
    end
    unique case (step_q)
      2'd0: begin
        mul_a = diff[0];
        mul_b = diff[0];
      end
      2'd1: begin
        mul_a = diff[1];
        mul_b = diff[1];
      end
      2'd2: begin
        mul_a = diff[2];
        mul_b = diff[2];
      end
      default: begin
        mul_a = thr_q;
        mul_b = thr_q;
      end
    endcase
  end

  always_comb begin
    scan_bkt_d = scan_bkt_q;
    if (scan_bkt_q[2] != LastBkt) begin
      scan_bkt_d[2] = scan_bkt_q[2] + BktW'(1);
    end else begin
      scan_bkt_d[2] = '0;
      if (scan_bkt_q[1] != LastBkt) begin
        scan_bkt_d[1] = scan_bkt_q[1] + BktW'(1);
      end else begin
        scan_bkt_d[1] = '0;
        scan_bkt_d[0] = scan_bkt_q[0] + BktW'(1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (scan_addr_q == LastBin) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (s_op)
            OP_START:   state_d = ST_CLEAR;
            OP_COUNT:   state_d = ST_CNT_RD;
            OP_COMPOSE: state_d = key_ready_q ? ST_MUL : ST_SCAN;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_CNT_RD:    state_d = ST_CNT_WR;
      ST_CNT_WR:    state_d = ST_IDLE;
      ST_SCAN: begin
        if (scan_addr_q == LastBin) begin
          state_d = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: state_d = ST_KEY;
      ST_KEY:       state_d = ST_MUL;
      ST_MUL: begin
        if (step_q == 2'd3) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = scan_addr_q;
    mem_wdata     = '0;
    mem_raddr     = scan_addr_q;
    unique case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_CLEAR: mem_we = 1'b1;
      ST_CNT_RD: mem_raddr = cnt_addr_q;
      ST_CNT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_addr_q;
        mem_wdata = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
      end
      default: ;
    endcase
  end

  dck_hist_ram #(
    .Depth(NumBins),
    .AddrW(BinW),
    .DataW(COUNT_BITS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      thr_q       <= ThresholdReset;
      key_ready_q <= 1'b0;
      scan_addr_q <= '0;
      cmp_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == ST_SCAN);
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (s_acc && (s_op == OP_START || s_op == OP_COUNT)) begin
        key_ready_q <= 1'b0;
      end
      if (state_q == ST_KEY) begin
        key_ready_q <= 1'b1;
      end
      if (s_acc) begin
        scan_addr_q <= '0;
      end else if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
        scan_addr_q <= scan_addr_q + BinW'(1);
      end
      if (state_q == ST_DECIDE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      fg_q       <= s_fg;
      bg_q       <= s_bg;
      cnt_addr_q <= bin_of(bucket_of(s_fg[0]), bucket_of(s_fg[1]), bucket_of(s_fg[2]));
      scan_bkt_q <= '0;
      best_cnt_q <= '0;
      best_bkt_q <= '0;
      step_q     <= 2'd0;
      acc_q      <= '0;
    end
    if (state_q == ST_SCAN) begin
      cmp_bkt_q  <= scan_bkt_q;
      scan_bkt_q <= scan_bkt_d;
    end
    if (cmp_vld_q && mem_rdata > best_cnt_q) begin
      best_cnt_q <= mem_rdata;
      best_bkt_q <= cmp_bkt_q;
    end
    if (state_q == ST_KEY) begin
      for (int c = 0; c < 3; c++) begin
        key_q[c] <= center_of(best_bkt_q[c]);
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= ProdW'(mul_a * mul_b);
      step_q <= step_q + 2'd1;
      if (step_q != 2'd0) begin
        acc_q <= acc_q + AccW'(prod_q);
      end
    end
    if (state_q == ST_DECIDE && out_free) begin
      out_pix_q <= rep ? bg_q : fg_q;
      out_rep_q <= rep;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tuser  = out_rep_q;

endmodule

FILE: design/dck_hist_ram.sv
// Histogram bin memory with one write port and one registered read port.
module dck_hist_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 24
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/dck_checker.sv
// Port-level checks of the dominant color chroma key block and their binding.
module dck_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  import dck_pkg::*;

  // A stalled result keeps its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A compose request keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_COMPOSE |=> !s_axis_tready)
    else $error("ready right after a compose request");

  // Requests other than compose never raise a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_COMPOSE && !m_axis_tvalid
      |=> !m_axis_tvalid)
    else $error("result without a compose request");

  // The histogram clear after reset holds off requests.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !s_axis_tready)
    else $error("ready during the clear after reset");

endmodule

bind dominant_color_chroma_key dck_checker u_dck_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
